// ----- rtl/scbl_pkg.sv -----
// Shared types and constants for the stereo cascaded biquad low-pass core.
// Depends on nothing; imported by the core module and its test.
package scbl_pkg;

   // Field and coefficient widths.
   localparam int SAMPLE_W = 32;
   localparam int COEF_W   = 32;

   // One coefficient digit is handled per cycle by the serial multiplier.
   localparam int DIGIT_W    = 8;
   localparam int NUM_DIGITS = COEF_W / DIGIT_W;
   localparam int DIGIT_CW   = $clog2(NUM_DIGITS);

   // Five products of 32 by 32 bits plus the rounding half fit in 67 bits.
   localparam int ACC_W  = 67;
   localparam int PROD_W = SAMPLE_W + COEF_W;

   // Defaults for the top-level parameters.
   localparam int NUM_STAGES_DEF     = 2;
   localparam int COEF_FRAC_BITS_DEF = 28;

   // Configuration register indexes.
   localparam int CSR_IDX_W = 3;
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_B0 = 3'd0,
      CSR_B1 = 3'd1,
      CSR_B2 = 3'd2,
      CSR_A1 = 3'd3,
      CSR_A2 = 3'd4
   } csr_index_type;

   // The five taps of one section, in the order they are accumulated.
   typedef enum logic [2:0] {
      TERM_B0 = 3'd0,
      TERM_B1 = 3'd1,
      TERM_B2 = 3'd2,
      TERM_A1 = 3'd3,
      TERM_A2 = 3'd4
   } term_type;

   // History of one section of one channel.
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] x1;
      logic signed [SAMPLE_W-1:0] x2;
      logic signed [SAMPLE_W-1:0] y1;
      logic signed [SAMPLE_W-1:0] y2;
   } hist_entry_type;

endpackage

// ----- rtl/stereo_cascaded_biquad_lowpass_core.sv -----
// Stereo cascaded biquad low-pass core, direct form I, with a digit-serial multiplier.
// Depends on scbl_pkg for widths, register indexes, tap codes and the history type.
//
//   Channel  Direction  Handshake            Payload
//   req      in         req_valid/req_stall  req_left_in, req_right_in
//   rsp      out        rsp_valid/rsp_stall  rsp_left_out, rsp_right_out
//   csr      in         csr_wr_en            csr_index, csr_wdata
//
// An item runs its 2 * NUM_STAGES sections one after another, first the left channel's
// and then the right's. Each section runs five taps of four 8-bit coefficient digits
// through the one shared multiplier, then the last add, then rounding.
// Reset is synchronous; it clears control state and history and sets unity-gain taps.
// A new item is accepted while an earlier result still waits in the output register; the
// finished result of that item is held inside until the output register frees up.
module stereo_cascaded_biquad_lowpass_core
   import scbl_pkg::*;
#(
   parameter int NUM_STAGES     = NUM_STAGES_DEF,
   parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic signed [SAMPLE_W-1:0] req_left_in,
   input  logic signed [SAMPLE_W-1:0] req_right_in,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [SAMPLE_W-1:0] rsp_left_out,
   output logic signed [SAMPLE_W-1:0] rsp_right_out,
   input  logic                       csr_wr_en,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [COEF_W-1:0]          csr_wdata
);

   localparam int NUM_SECT = 2 * NUM_STAGES;
   localparam int SECT_W   = $clog2(NUM_SECT);
   localparam int T_W      = SAMPLE_W + DIGIT_W + 2;
   localparam int P_W      = T_W - DIGIT_W;
   localparam int HIGH_W   = PROD_W - (COEF_W - DIGIT_W);

   localparam logic [COEF_W-1:0] B0_RESET = COEF_W'(1) << COEF_FRAC_BITS;
   localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) <<< (COEF_FRAC_BITS - 1);
   localparam logic signed [ACC_W-1:0] SAT_HI = (ACC_W'(1) <<< (SAMPLE_W - 1)) - ACC_W'(1);
   localparam logic signed [ACC_W-1:0] SAT_LO = -(ACC_W'(1) <<< (SAMPLE_W - 1));
   localparam logic [SECT_W-1:0] SECT_LEFT_END = SECT_W'(NUM_STAGES - 1);
   localparam logic [SECT_W-1:0] SECT_LAST     = SECT_W'(NUM_SECT - 1);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_MAC    = 5'b00010,
      ST_FLUSH  = 5'b00100,
      ST_ROUND  = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

   state_type                  state_ff, state_in;
   term_type                   term_ff, term_in;
   logic [DIGIT_CW-1:0]        dig_ff, dig_in;
   logic [SECT_W-1:0]          sect_ff, sect_in;
   logic                       prod_vld_ff, prod_vld_in;
   logic                       prod_sub_ff, prod_sub_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   hist_entry_type             hist_ff [NUM_SECT];
   hist_entry_type             hist_in [NUM_SECT];

   logic [COEF_W-1:0]          b0_ff, b1_ff, b2_ff, a1_ff, a2_ff;
   logic signed [SAMPLE_W-1:0] cur_x_ff, cur_x_in;
   logic signed [SAMPLE_W-1:0] right_ff, right_in;
   logic signed [SAMPLE_W-1:0] left_res_ff, left_res_in;
   logic signed [SAMPLE_W-1:0] right_res_ff, right_res_in;
   logic signed [SAMPLE_W-1:0] samp_ff, samp_in;
   logic [COEF_W-1:0]          coef_sr_ff, coef_sr_in;
   logic [COEF_W-1:0]          low_ff, low_in;
   logic signed [P_W-1:0]      p_ff, p_in;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   logic signed [SAMPLE_W-1:0] out_left_ff, out_left_in;
   logic signed [SAMPLE_W-1:0] out_right_ff, out_right_in;

   logic                       req_take;
   logic                       out_free;
   logic                       dig_first, dig_last;
   logic [COEF_W-1:0]          coef_sel, coef_cur;
   logic signed [SAMPLE_W-1:0] samp_sel, samp_cur;
   logic signed [DIGIT_W:0]    dig_s;
   logic signed [SAMPLE_W+DIGIT_W:0] mul;
   logic signed [T_W-1:0]      t_sum;
   logic signed [ACC_W-1:0]    acc_add;
   logic signed [ACC_W-1:0]    rnd_sum, rnd_q;
   logic signed [SAMPLE_W-1:0] y_sat;
   hist_entry_type             new_entry;

   // Handshake decode.
   assign req_stall = reset | (state_ff != ST_IDLE);
   assign req_take  = req_valid & ~req_stall;
   assign out_free  = ~rsp_valid_ff | ~rsp_stall;

   assign dig_first = (dig_ff == '0);
   assign dig_last  = (dig_ff == DIGIT_CW'(NUM_DIGITS - 1));

   // Tap operands for the current term.
   always_comb begin
      unique case (term_ff)
         TERM_B0: begin coef_sel = b0_ff; samp_sel = cur_x_ff;      end
         TERM_B1: begin coef_sel = b1_ff; samp_sel = hist_ff[0].x1; end
         TERM_B2: begin coef_sel = b2_ff; samp_sel = hist_ff[0].x2; end
         TERM_A1: begin coef_sel = a1_ff; samp_sel = hist_ff[0].y1; end
         TERM_A2: begin coef_sel = a2_ff; samp_sel = hist_ff[0].y2; end
         default: begin coef_sel = b0_ff; samp_sel = cur_x_ff;      end
      endcase
   end

   // Serial multiplier: one coefficient digit per cycle, lowest digit first. The lower
   // digits are unsigned and the top digit carries the coefficient's sign.
   assign coef_cur = dig_first ? coef_sel : coef_sr_ff;
   assign samp_cur = dig_first ? samp_sel : samp_ff;
   assign dig_s    = dig_last ? $signed({coef_cur[DIGIT_W-1], coef_cur[DIGIT_W-1:0]})
                              : $signed({1'b0, coef_cur[DIGIT_W-1:0]});
   assign mul      = samp_cur * dig_s;
   assign t_sum    = T_W'(p_ff) + T_W'(mul);

   // Accumulator input: the product finished in the previous cycle, added or subtracted.
   assign acc_add = prod_sub_ff ? acc_ff - ACC_W'(prod_ff) : acc_ff + ACC_W'(prod_ff);

   // Round to nearest (ties upward) and saturate to the sample width.
   assign rnd_sum = acc_ff + ROUND_HALF;
   assign rnd_q   = rnd_sum >>> COEF_FRAC_BITS;
   always_comb begin
      priority if (rnd_q > SAT_HI) begin
         y_sat = SAT_HI[SAMPLE_W-1:0];
      end else if (rnd_q < SAT_LO) begin
         y_sat = SAT_LO[SAMPLE_W-1:0];
      end else begin
         y_sat = rnd_q[SAMPLE_W-1:0];
      end
   end

   assign new_entry = '{x1: cur_x_ff, x2: hist_ff[0].x1, y1: y_sat, y2: hist_ff[0].y1};

   // Sequencer and datapath next values.
   always_comb begin
      state_in     = state_ff;
      term_in      = term_ff;
      dig_in       = dig_ff;
      sect_in      = sect_ff;
      prod_vld_in  = 1'b0;
      prod_sub_in  = prod_sub_ff;
      hist_in      = hist_ff;
      cur_x_in     = cur_x_ff;
      right_in     = right_ff;
      left_res_in  = left_res_ff;
      right_res_in = right_res_ff;
      samp_in      = samp_ff;
      coef_sr_in   = coef_sr_ff;
      low_in       = low_ff;
      p_in         = p_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      out_left_in  = out_left_ff;
      out_right_in = out_right_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               cur_x_in = req_left_in;
               right_in = req_right_in;
               term_in  = TERM_B0;
               dig_in   = '0;
               sect_in  = '0;
               p_in     = '0;
               acc_in   = '0;
               state_in = ST_MAC;
            end
         end
         ST_MAC: begin
            samp_in    = samp_cur;
            coef_sr_in = coef_cur >> DIGIT_W;
            low_in     = {t_sum[DIGIT_W-1:0], low_ff[COEF_W-1:DIGIT_W]};
            if (prod_vld_ff) begin
               acc_in = acc_add;
            end
            if (dig_last) begin
               // The last digit closes the product; it is added in the next cycle.
               prod_in     = {t_sum[HIGH_W-1:0], low_ff[COEF_W-1:DIGIT_W]};
               prod_vld_in = 1'b1;
               prod_sub_in = (term_ff == TERM_A1) || (term_ff == TERM_A2);
               p_in        = '0;
               dig_in      = '0;
               unique case (term_ff)
                  TERM_B0: term_in = TERM_B1;
                  TERM_B1: term_in = TERM_B2;
                  TERM_B2: term_in = TERM_A1;
                  TERM_A1: term_in = TERM_A2;
                  TERM_A2: begin
                     term_in  = TERM_B0;
                     state_in = ST_FLUSH;
                  end
                  default: term_in = TERM_B0;
               endcase
            end else begin
               p_in   = t_sum[T_W-1:DIGIT_W];
               dig_in = dig_ff + DIGIT_CW'(1);
            end
         end
         ST_FLUSH: begin
            acc_in   = acc_add;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            // Rotate the history so that the next section's entry comes to the front.
            for (int i = 0; i < NUM_SECT - 1; i++) begin
               hist_in[i] = hist_ff[i+1];
            end
            hist_in[NUM_SECT-1] = new_entry;
            acc_in = '0;
            if (sect_ff == SECT_LAST) begin
               right_res_in = y_sat;
               sect_in      = '0;
               state_in     = ST_FINISH;
            end else begin
               if (sect_ff == SECT_LEFT_END) begin
                  left_res_in = y_sat;
                  cur_x_in    = right_ff;
               end else begin
                  cur_x_in = y_sat;
               end
               sect_in  = sect_ff + SECT_W'(1);
               state_in = ST_MAC;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               out_left_in  = left_res_ff;
               out_right_in = right_res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control state, history and coefficients.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         term_ff      <= TERM_B0;
         dig_ff       <= '0;
         sect_ff      <= '0;
         prod_vld_ff  <= 1'b0;
         prod_sub_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_SECT; i++) begin
            hist_ff[i] <= '0;
         end
         b0_ff <= B0_RESET;
         b1_ff <= '0;
         b2_ff <= '0;
         a1_ff <= '0;
         a2_ff <= '0;
      end else begin
         state_ff     <= state_in;
         term_ff      <= term_in;
         dig_ff       <= dig_in;
         sect_ff      <= sect_in;
         prod_vld_ff  <= prod_vld_in;
         prod_sub_ff  <= prod_sub_in;
         rsp_valid_ff <= rsp_valid_in;
         hist_ff      <= hist_in;
         // Writes to indexes beyond the register list are dropped.
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_B0:  b0_ff <= csr_wdata;
               CSR_B1:  b1_ff <= csr_wdata;
               CSR_B2:  b2_ff <= csr_wdata;
               CSR_A1:  a1_ff <= csr_wdata;
               CSR_A2:  a2_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cur_x_ff     <= cur_x_in;
      right_ff     <= right_in;
      left_res_ff  <= left_res_in;
      right_res_ff <= right_res_in;
      samp_ff      <= samp_in;
      coef_sr_ff   <= coef_sr_in;
      low_ff       <= low_in;
      p_ff         <= p_in;
      prod_ff      <= prod_in;
      acc_ff       <= acc_in;
      out_left_ff  <= out_left_in;
      out_right_ff <= out_right_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_left_out  = out_left_ff;
   assign rsp_right_out = out_right_ff;

   // An accepted item always starts with the first tap of the first section.
   a_start: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> state_ff == ST_MAC && sect_ff == '0 && dig_ff == '0)
      else $error("item accepted but the sequencer did not start at the first section");

   // A new result appears only when a finished item leaves the holding state.
   a_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == ST_FINISH))
      else $error("result register loaded outside the finish state");

   // The idle sequencer holds no pending product and points at the first section.
   a_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !prod_vld_ff && sect_ff == '0)
      else $error("idle with a pending product or a stray section index");

endmodule

// ----- tb/sv/stereo_cascaded_biquad_lowpass_core_test.sv -----
// Self-checking test of the stereo cascaded biquad low-pass core.
// Depends on scbl_pkg and stereo_cascaded_biquad_lowpass_core; predicts every filtered item
// with its own fixed-point direct form I filter and compares it with the core's output.
module stereo_cascaded_biquad_lowpass_core_test
   import scbl_pkg::*;
();

   localparam int NUM_STAGES = NUM_STAGES_DEF;
   localparam int FRAC_BITS  = COEF_FRAC_BITS_DEF;
   localparam int NUM_CH     = 2;
   localparam int WIDE_W     = 96;
   localparam int QUIET_LIMIT = 2000;
   localparam int HOLD_CYCLES = 300;

   localparam logic signed [WIDE_W-1:0] ROUND_HALF = 96'sd1 <<< (FRAC_BITS - 1);
   localparam logic signed [WIDE_W-1:0] SAT_HIGH   = 96'sd2147483647;
   localparam logic signed [WIDE_W-1:0] SAT_LOW    = -96'sd2147483648;
   localparam logic signed [SAMPLE_W-1:0] PEAK_POS = 32'sh7fffffff;
   localparam logic signed [SAMPLE_W-1:0] PEAK_NEG = 32'sh80000000;
   localparam logic signed [COEF_W-1:0]   UNITY    = 32'sd1 <<< FRAC_BITS;

   typedef struct {
      logic signed [SAMPLE_W-1:0] left_out;
      logic signed [SAMPLE_W-1:0] right_out;
   } stereo_frame_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic signed [SAMPLE_W-1:0] req_left_in = '0;
   logic signed [SAMPLE_W-1:0] req_right_in = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic signed [SAMPLE_W-1:0] rsp_left_out;
   logic signed [SAMPLE_W-1:0] rsp_right_out;
   logic                       csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]       csr_index = '0;
   logic [COEF_W-1:0]          csr_wdata = '0;

   // Filter state of the predictor: shared taps and per-section history.
   logic signed [COEF_W-1:0] coef_set [0:CSR_A2];
   hist_entry_type           section_hist [NUM_CH*NUM_STAGES];
   stereo_frame_type         filtered_frames [$];
   stereo_frame_type         oldest_frame;

   int failures = 0;
   int quiet_cycles = 0;
   int hold_count = 0;
   bit calm = 1'b0;

   stereo_cascaded_biquad_lowpass_core #(
      .NUM_STAGES     (NUM_STAGES),
      .COEF_FRAC_BITS (FRAC_BITS)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_left_in   (req_left_in),
      .req_right_in  (req_right_in),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_left_out  (rsp_left_out),
      .rsp_right_out (rsp_right_out),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   // Clock with a period of 10.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // One biquad section: exact sum of the five taps, round half up, clamp to 32 bits.
   function automatic logic signed [SAMPLE_W-1:0] run_section(
      input logic signed [SAMPLE_W-1:0] x, input int k);
      logic signed [WIDE_W-1:0]   acc;
      logic signed [WIDE_W-1:0]   scaled;
      logic signed [SAMPLE_W-1:0] y;
      acc = coef_set[CSR_B0] * x
          + coef_set[CSR_B1] * $signed(section_hist[k].x1)
          + coef_set[CSR_B2] * $signed(section_hist[k].x2)
          - coef_set[CSR_A1] * $signed(section_hist[k].y1)
          - coef_set[CSR_A2] * $signed(section_hist[k].y2)
          + ROUND_HALF;
      scaled = acc >>> FRAC_BITS;
      if (scaled > SAT_HIGH) begin
         y = PEAK_POS;
      end else if (scaled < SAT_LOW) begin
         y = PEAK_NEG;
      end else begin
         y = scaled[SAMPLE_W-1:0];
      end
      section_hist[k].x2 = section_hist[k].x1;
      section_hist[k].x1 = x;
      section_hist[k].y2 = section_hist[k].y1;
      section_hist[k].y1 = y;
      return y;
   endfunction

   // Both channels through the whole cascade.
   function automatic stereo_frame_type lowpass_frame(
      input logic signed [SAMPLE_W-1:0] left, input logic signed [SAMPLE_W-1:0] right);
      stereo_frame_type f;
      f.left_out  = left;
      f.right_out = right;
      for (int s = 0; s < NUM_STAGES; s++) begin
         f.left_out  = run_section(f.left_out, s);
         f.right_out = run_section(f.right_out, NUM_STAGES + s);
      end
      return f;
   endfunction

   // Audio-like sample: mostly full scale noise, some quieter, some at the rails.
   function automatic logic signed [SAMPLE_W-1:0] audio_sample();
      logic signed [SAMPLE_W-1:0] s;
      s = $urandom;
      case ($urandom_range(9))
         0, 1: s = s >>> $urandom_range(31);
         2: s = $urandom_range(1) ? PEAK_POS : PEAK_NEG;
         default: ;
      endcase
      return s;
   endfunction

   // Offer one item, wait until it is taken, and record its expected result.
   task automatic send_frame(input logic signed [SAMPLE_W-1:0] left,
                             input logic signed [SAMPLE_W-1:0] right);
      if (!calm) begin
         while ($urandom_range(99) < 32) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid    <= 1'b1;
      req_left_in  <= left;
      req_right_in <= right;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      filtered_frames.push_back(lowpass_frame(left, right));
   endtask

   task automatic play_noise(input int count);
      repeat (count) send_frame(audio_sample(), audio_sample());
   endtask

   // Stop offering items and wait until every expected result has come back.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (filtered_frames.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [COEF_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      if (idx <= CSR_A2) coef_set[idx] = value;
   endtask

   task automatic set_coefs(input logic signed [COEF_W-1:0] b0, input logic signed [COEF_W-1:0] b1,
                            input logic signed [COEF_W-1:0] b2, input logic signed [COEF_W-1:0] a1,
                            input logic signed [COEF_W-1:0] a2);
      wait_idle();
      write_reg(CSR_B0, b0);
      write_reg(CSR_B1, b1);
      write_reg(CSR_B2, b2);
      write_reg(CSR_A1, a1);
      write_reg(CSR_A2, a2);
      csr_wr_en <= 1'b0;
   endtask

   // Reset taps pass the input straight through; check the extremes of both fields.
   task automatic test_passthrough();
      send_frame(32'sd0, 32'sd0);
      send_frame(32'sd1, -32'sd1);
      send_frame(PEAK_POS, PEAK_NEG);
      send_frame(PEAK_NEG, PEAK_POS);
      send_frame(32'sh55555555, 32'shaaaaaaaa);
      send_frame(32'shaaaaaaaa, 32'sh55555555);
      send_frame(-32'sd1, 32'sd1);
      send_frame(32'sd0, PEAK_POS);
   endtask

   // A gain of 2^-14 per section puts exact halves on the second section's rounding.
   task automatic test_rounding_ties();
      set_coefs(32'sd1 <<< (FRAC_BITS - 14), 32'sd0, 32'sd0, 32'sd0, 32'sd0);
      send_frame(32'sd1 <<< 27, -(32'sd1 <<< 27));
      send_frame(32'sd3 <<< 27, -(32'sd3 <<< 27));
      send_frame(-(32'sd3 <<< 27), 32'sd3 <<< 27);
      send_frame(32'sd0, 32'sd0);
   endtask

   // Largest and smallest taps drive every section into its clamps.
   task automatic test_saturation();
      set_coefs(PEAK_POS, PEAK_POS, PEAK_POS, PEAK_POS, PEAK_POS);
      send_frame(PEAK_POS, PEAK_NEG);
      send_frame(PEAK_NEG, PEAK_POS);
      send_frame(PEAK_POS, PEAK_POS);
      send_frame(32'sd1, -32'sd1);
      set_coefs(PEAK_NEG, PEAK_NEG, PEAK_NEG, PEAK_NEG, PEAK_NEG);
      send_frame(PEAK_NEG, PEAK_NEG);
      send_frame(PEAK_POS, PEAK_NEG);
      send_frame(32'sd0, 32'sd0);
      send_frame(-32'sd1, PEAK_POS);
   endtask

   // Writes past the last register must leave the taps alone.
   task automatic test_bad_index();
      set_coefs(UNITY, 32'sd0, 32'sd0, 32'sd0, 32'sd0);
      for (int i = CSR_A2 + 1; i < 2 ** CSR_IDX_W; i++) begin
         write_reg(CSR_IDX_W'(i), $urandom);
      end
      csr_wr_en <= 1'b0;
      send_frame(32'sd12345, -32'sd54321);
      send_frame(PEAK_POS, PEAK_NEG);
      send_frame(audio_sample(), audio_sample());
   endtask

   // Receiver holds off for a long stretch while items keep coming.
   task automatic test_backpressure();
      hold_count = HOLD_CYCLES;
      play_noise(40);
   endtask

   // Two stable low-pass designs, switched mid-stream with the history kept.
   task automatic test_lowpass();
      set_coefs(32'sd1051190, 32'sd2102380, 32'sd1051190, -32'sd487295715, 32'sd223065032);
      calm = 1'b1;
      play_noise(250);
      calm = 1'b0;
      play_noise(350);
      set_coefs(32'sd41620920, 32'sd83241840, 32'sd41620920, -32'sd166483669, 32'sd64529200);
      play_noise(500);
   endtask

   // Random taps of varied magnitude over the whole range.
   task automatic test_random_coefs();
      for (int n = 0; n < 6; n++) begin
         set_coefs($signed($urandom) >>> $urandom_range(6), $signed($urandom) >>> $urandom_range(6),
                   $signed($urandom) >>> $urandom_range(6), $signed($urandom) >>> $urandom_range(6),
                   $signed($urandom) >>> $urandom_range(6));
         play_noise(110);
      end
   endtask

   // Receiver: random stalls, calm stretches, and a counted hold-off on request.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_count > 0) begin
            rsp_stall <= 1'b1;
            hold_count--;
         end else begin
            rsp_stall <= calm ? 1'b0 : ($urandom_range(99) < 32);
         end
      end
   end

   // Compare each accepted result with the oldest expected item.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (filtered_frames.size() == 0) begin
            $error("unexpected result: left_out %0d, right_out %0d", rsp_left_out, rsp_right_out);
            failures++;
         end else begin
            oldest_frame = filtered_frames.pop_front();
            if (rsp_left_out !== oldest_frame.left_out) begin
               $error("left_out: expected %0d, actual %0d", oldest_frame.left_out, rsp_left_out);
               failures++;
            end
            if (rsp_right_out !== oldest_frame.right_out) begin
               $error("right_out: expected %0d, actual %0d", oldest_frame.right_out,
                      rsp_right_out);
               failures++;
            end
         end
      end
   end

   // Watchdog on cycles in which neither channel moves an item.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles == QUIET_LIMIT) begin
         $display("watchdog: no item moved for %0d cycles", QUIET_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Test sequence.
   initial begin
      coef_set[CSR_B0] = UNITY;
      coef_set[CSR_B1] = '0;
      coef_set[CSR_B2] = '0;
      coef_set[CSR_A1] = '0;
      coef_set[CSR_A2] = '0;
      for (int i = 0; i < NUM_CH * NUM_STAGES; i++) section_hist[i] = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_passthrough();
      test_rounding_ties();
      test_saturation();
      test_bad_index();
      test_backpressure();
      play_noise(150);
      test_lowpass();
      test_random_coefs();
      wait_idle();
      repeat (200) @(posedge clock);
      if (failures == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
